FILE: sv/fpr_pkg.sv
// Package for the framed packet receiver.
// Holds the register reset values, status codes and the shared structs.
// No dependencies.
package fpr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] SyncFirstRst = 8'h00;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'h00;
  localparam logic [ByteW-1:0] HuntTriesRst = 8'd20;
  localparam logic [ByteW-1:0] MaxLengthRst = 8'd64;
  localparam logic [ByteW-1:0] ChecksumBase = 8'hFF;

  localparam logic [CfgIdxW-1:0] CfgSyncFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHuntTries  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxLength  = 2'd3;

  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StHeader = 2'd1;
  localparam logic [StatusW-1:0] StSize   = 2'd2;
  localparam logic [StatusW-1:0] StCsum   = 2'd3;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] hunt_tries;
    logic [ByteW-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [ByteW-1:0]   data_byte;
    logic [ByteW-1:0]   command_id;
    logic [ByteW-1:0]   payload_length;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

FILE: sv/fpr_cfg_regs.sv
// Configuration register bank of the framed packet receiver.
// Depends on fpr_pkg for the register indexes and reset values.
module fpr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fpr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fpr_pkg::ByteW-1:0]    cfg_data_i,
  output fpr_pkg::cfg_t                cfg_o
);
  import fpr_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SyncFirstRst;
      cfg_q.sync_second <= SyncSecondRst;
      cfg_q.hunt_tries  <= HuntTriesRst;
      cfg_q.max_length  <= MaxLengthRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSyncFirst:  cfg_q.sync_first  <= cfg_data_i;
        CfgSyncSecond: cfg_q.sync_second <= cfg_data_i;
        CfgHuntTries:  cfg_q.hunt_tries  <= cfg_data_i;
        CfgMaxLength:  cfg_q.max_length  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/fpr_parser.sv
// Input register and packet parsing state machine of the framed packet receiver.
// Depends on fpr_pkg for the configuration and result structs.
module fpr_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fpr_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [fpr_pkg::ByteW-1:0] rx_byte_i,
  input  logic                      res_ready_i,
  output logic                      res_valid_o,
  output fpr_pkg::result_t          res_o
);
  import fpr_pkg::*;

  localparam logic [2:0] PhSync1 = 3'd0;
  localparam logic [2:0] PhSync2 = 3'd1;
  localparam logic [2:0] PhCmd   = 3'd2;
  localparam logic [2:0] PhLen   = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;
  localparam logic [2:0] PhCheck = 3'd5;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             step;

  logic [2:0]       phase_q, phase_d;
  logic [ByteW-1:0] failed_q, failed_d;
  logic [ByteW-1:0] command_q, command_d;
  logic [ByteW-1:0] length_q, length_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [ByteW-1:0] sum_q, sum_d;

  logic [ByteW-1:0] limit;
  logic [ByteW:0]   tries_next;
  logic             tries_hit;
  logic [ByteW-1:0] left_dec;
  logic             has_res;
  result_t          res;

  assign step       = in_valid_q && res_ready_i;
  assign in_ready_o = !in_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // A hunt limit of zero acts as a limit of one.
  assign limit      = (cfg_i.hunt_tries == '0) ? ByteW'(1) : cfg_i.hunt_tries;
  assign tries_next = {1'b0, failed_q} + (ByteW+1)'(1);
  assign tries_hit  = tries_next >= {1'b0, limit};
  assign left_dec   = left_q - ByteW'(1);

  always_comb begin
    phase_d            = phase_q;
    failed_d           = failed_q;
    command_d          = command_q;
    length_d           = length_q;
    left_d             = left_q;
    sum_d              = sum_q;
    has_res            = 1'b0;
    res.kind           = KindStatus;
    res.data_byte      = '0;
    res.command_id     = '0;
    res.payload_length = '0;
    res.status         = StOk;
    case (phase_q)
      PhSync2: begin
        if (in_byte_q == cfg_i.sync_second) begin
          failed_d = '0;
          phase_d  = PhCmd;
        end else begin
          phase_d = PhSync1;
          if (tries_hit) begin
            failed_d   = '0;
            has_res    = 1'b1;
            res.status = StHeader;
          end else begin
            failed_d = tries_next[ByteW-1:0];
          end
        end
      end
      PhCmd: begin
        command_d = in_byte_q;
        phase_d   = PhLen;
      end
      PhLen: begin
        length_d = in_byte_q;
        sum_d    = '0;
        if (in_byte_q > cfg_i.max_length) begin
          phase_d            = PhSync1;
          has_res            = 1'b1;
          res.command_id     = command_q;
          res.payload_length = in_byte_q;
          res.status         = StSize;
        end else begin
          left_d  = in_byte_q;
          phase_d = (in_byte_q == '0) ? PhCheck : PhData;
        end
      end
      PhData: begin
        sum_d  = sum_q + in_byte_q;
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = PhCheck;
        end
        has_res            = 1'b1;
        res.kind           = KindData;
        res.data_byte      = in_byte_q;
        res.command_id     = command_q;
        res.payload_length = length_q;
      end
      PhCheck: begin
        phase_d            = PhSync1;
        has_res            = 1'b1;
        res.command_id     = command_q;
        res.payload_length = length_q;
        res.status         = (in_byte_q == (ChecksumBase - sum_q)) ? StOk : StCsum;
      end
      default: begin
        if (in_byte_q == cfg_i.sync_first) begin
          phase_d = PhSync2;
        end else begin
          phase_d = PhSync1;
          if (tries_hit) begin
            failed_d   = '0;
            has_res    = 1'b1;
            res.status = StHeader;
          end else begin
            failed_d = tries_next[ByteW-1:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhSync1;
      failed_q  <= '0;
      command_q <= '0;
      length_q  <= '0;
      left_q    <= '0;
      sum_q     <= '0;
    end else if (step) begin
      phase_q   <= phase_d;
      failed_q  <= failed_d;
      command_q <= command_d;
      length_q  <= length_d;
      left_q    <= left_d;
      sum_q     <= sum_d;
    end
  end

  assign res_valid_o = step && has_res;
  assign res_o       = res;

endmodule

FILE: sv/fpr_out_stage.sv
// Result register of the framed packet receiver.
// Depends on fpr_pkg for the result struct.
module fpr_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  output logic             res_ready_o,
  input  fpr_pkg::result_t res_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fpr_pkg::result_t out_o
);
  import fpr_pkg::*;

  logic    out_valid_q;
  result_t out_q;

  assign res_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: sv/framed_packet_receiver_unit.sv
// Framed packet receiver: takes one received byte per beat and parses packets of the form
// sync, sync, command, length, payload, checksum. A new byte is accepted every clock cycle
// as long as results are taken; each byte passes an input register, one step of the parsing
// state machine and a result register, from which its result is taken. While a result waits
// and a byte is held in the input register, the input ready follows the output ready.
// Payload bytes come out as they arrive, and a status beat closes each packet or reports a
// header or size error.
// Depends on fpr_pkg, fpr_cfg_regs, fpr_parser and fpr_out_stage.
module framed_packet_receiver_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fpr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fpr_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [fpr_pkg::ByteW-1:0]    rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         kind_o,
  output logic [fpr_pkg::ByteW-1:0]    data_byte_o,
  output logic [fpr_pkg::ByteW-1:0]    command_id_o,
  output logic [fpr_pkg::ByteW-1:0]    payload_length_o,
  output logic [fpr_pkg::StatusW-1:0]  status_o
);
  import fpr_pkg::*;

  cfg_t    cfg;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out;

  fpr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fpr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fpr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out)
  );

  assign kind_o           = out.kind;
  assign data_byte_o      = out.data_byte;
  assign command_id_o     = out.command_id;
  assign payload_length_o = out.payload_length;
  assign status_o         = out.status;

endmodule

FILE: tb/framed_packet_receiver_unit_test.sv
// Testbench for framed_packet_receiver_unit: directed and random byte streams under several
// register settings and handshake idling patterns, checked beat by beat against a scoreboard.
// Depends on fpr_pkg and the framed_packet_receiver_unit RTL.
module framed_packet_receiver_unit_test;
  import fpr_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef enum logic [2:0] {
    HuntFirst, HuntSecond, TakeCommand, TakeLength, TakePayload, TakeChecksum
  } parse_phase_e;

  class packet_scoreboard;
    cfg_t             regs;
    parse_phase_e     phase;
    logic [ByteW-1:0] failed_tries;
    logic [ByteW-1:0] held_command;
    logic [ByteW-1:0] held_length;
    logic [ByteW-1:0] bytes_left;
    logic [ByteW-1:0] running_sum;
    result_t          expected_q[$];
    int               mismatches;
    int               payload_beats;
    int               status_seen[4];

    function new();
      regs.sync_first = SyncFirstRst;
      regs.sync_second = SyncSecondRst;
      regs.hunt_tries = HuntTriesRst;
      regs.max_length = MaxLengthRst;
      phase = HuntFirst;
      failed_tries = '0;
      held_command = '0;
      held_length = '0;
      bytes_left = '0;
      running_sum = '0;
      mismatches = 0;
      payload_beats = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        CfgSyncFirst:  regs.sync_first = val;
        CfgSyncSecond: regs.sync_second = val;
        CfgHuntTries:  regs.hunt_tries = val;
        CfgMaxLength:  regs.max_length = val;
        default: ;
      endcase
    endfunction

    function void push_beat(logic kind, logic [ByteW-1:0] data, logic [StatusW-1:0] st);
      result_t r;
      r.kind = kind;
      r.data_byte = data;
      r.command_id = held_command;
      r.payload_length = held_length;
      r.status = st;
      expected_q.push_back(r);
    endfunction

    function void miss_try();
      int limit;
      int n;
      limit = (regs.hunt_tries == 0) ? 1 : int'(regs.hunt_tries);
      n = int'(failed_tries) + 1;
      phase = HuntFirst;
      if (n >= limit) begin
        failed_tries = '0;
        held_command = '0;
        held_length = '0;
        push_beat(KindStatus, '0, StHeader);
      end else begin
        failed_tries = 8'(n);
      end
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      case (phase)
        HuntFirst: begin
          if (b == regs.sync_first) phase = HuntSecond;
          else miss_try();
        end
        HuntSecond: begin
          if (b == regs.sync_second) begin
            failed_tries = '0;
            phase = TakeCommand;
          end else begin
            miss_try();
          end
        end
        TakeCommand: begin
          held_command = b;
          phase = TakeLength;
        end
        TakeLength: begin
          held_length = b;
          running_sum = '0;
          if (b > regs.max_length) begin
            phase = HuntFirst;
            push_beat(KindStatus, '0, StSize);
          end else begin
            bytes_left = b;
            phase = (b == 0) ? TakeChecksum : TakePayload;
          end
        end
        TakePayload: begin
          running_sum = running_sum + b;
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == 0) phase = TakeChecksum;
          push_beat(KindData, b, StOk);
        end
        default: begin
          phase = HuntFirst;
          push_beat(KindStatus, '0, (b == ChecksumBase - running_sum) ? StOk : StCsum);
        end
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("beat with nothing pending: kind %0d data %02h cmd %02h len %02h st %0d",
                         got.kind, got.data_byte, got.command_id, got.payload_length,
                         got.status));
        return;
      end
      exp = expected_q.pop_front();
      if (got.kind !== exp.kind || got.data_byte !== exp.data_byte ||
          got.command_id !== exp.command_id || got.payload_length !== exp.payload_length ||
          got.status !== exp.status) begin
        report($sformatf("got kind %0d data %02h cmd %02h len %02h st %0d, want %0d %02h %02h %02h %0d",
                         got.kind, got.data_byte, got.command_id, got.payload_length,
                         got.status, exp.kind, exp.data_byte, exp.command_id,
                         exp.payload_length, exp.status));
      end
      if (exp.kind == KindData) payload_beats++;
      else status_seen[exp.status]++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [ByteW-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [ByteW-1:0]     rx_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 kind_o;
  logic [ByteW-1:0]     data_byte_o;
  logic [ByteW-1:0]     command_id_o;
  logic [ByteW-1:0]     payload_length_o;
  logic [StatusW-1:0]   status_o;

  packet_scoreboard sb;
  int unsigned      cycle_count = 0;
  int               send_gap_pct = 0;
  int               stall_pct = 0;
  int               sent_in_phase = 0;
  int               total_bytes = 0;

  framed_packet_receiver_unit DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[framed_packet_receiver_unit] ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = kind_o;
      got.data_byte = data_byte_o;
      got.command_id = command_id_o;
      got.payload_length = payload_length_o;
      got.status = status_o;
      sb.check_result(got);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i = b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
    sent_in_phase++;
    total_bytes++;
    @(negedge clk_i);
  endtask

  task automatic drain_results(input int settle);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(input logic [ByteW-1:0] sf, input logic [ByteW-1:0] ss,
                            input logic [ByteW-1:0] ht, input logic [ByteW-1:0] ml);
    drain_results(8);
    write_reg(CfgSyncFirst, sf);
    write_reg(CfgSyncSecond, ss);
    write_reg(CfgHuntTries, ht);
    write_reg(CfgMaxLength, ml);
  endtask

  task automatic send_packet();
    int               r;
    int               len;
    int               top;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    r = $urandom_range(99);
    top = int'(sb.regs.max_length);
    if (r < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
    end else if (r < 13) begin
      send_byte(sb.regs.sync_first);
      send_byte(sb.regs.sync_second ^ 8'($urandom_range(1, 255)));
    end else begin
      send_byte(sb.regs.sync_first);
      send_byte(sb.regs.sync_second);
      send_byte(8'($urandom_range(255)));
      r = $urandom_range(99);
      if (r < 10 && top < 255) begin
        send_byte(8'($urandom_range(top + 1, 255)));
      end else begin
        if (r < 13) len = top;
        else len = $urandom_range(0, (top < 12) ? top : 12);
        send_byte(8'(len));
        sum = '0;
        repeat (len) begin
          b = 8'($urandom_range(255));
          sum = sum + b;
          send_byte(b);
        end
        if ($urandom_range(99) < 85) send_byte(ChecksumBase - sum);
        else send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    logic [ByteW-1:0] directed [26];
    logic [ByteW-1:0] sf;
    logic [ByteW-1:0] ss;
    logic [ByteW-1:0] ht;
    logic [ByteW-1:0] ml;
    bit               paused;
    directed = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
                 8'hFF, 8'h00, 8'hFF, 8'h02, 8'hFF, 8'h01, 8'h12,
                 8'hFF, 8'h00, 8'h07, 8'h05,
                 8'h12, 8'h34, 8'hFF, 8'h55,
                 8'hFF, 8'h00, 8'hAA, 8'h01, 8'h80, 8'h7F};
    paused = 1'b0;
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_config(8'hFF, 8'h00, 8'd3, 8'd4);
    foreach (directed[i]) send_byte(directed[i]);

    for (int p = 0; p < 8; p++) begin
      sf = 8'($urandom_range(255));
      ss = 8'($urandom_range(255));
      ht = 8'($urandom_range(1, 8));
      ml = 8'($urandom_range(1, 40));
      case (p)
        0: begin sf = 8'h00; ss = 8'hFF; ht = 8'd1; ml = 8'd0; end
        1: begin sf = 8'hFF; ss = 8'hFF; ht = 8'd255; ml = 8'd255; end
        2: begin ht = 8'd0; ml = 8'd16; end
        3: begin ss = sf; ht = 8'd2; ml = 8'd64; end
        default: ;
      endcase
      set_config(sf, ss, ht, ml);
      case (p % 4)
        0: begin send_gap_pct = 0; stall_pct = 0; end
        1: begin send_gap_pct = 84; stall_pct = 0; end
        2: begin send_gap_pct = 0; stall_pct = 84; end
        default: begin send_gap_pct = 31; stall_pct = 31; end
      endcase
      sent_in_phase = 0;
      while (sent_in_phase < 125) begin
        if (p == 5 && !paused && sent_in_phase >= 60) begin
          drain_results(0);
          paused = 1'b1;
        end
        send_packet();
      end
    end

    drain_results(8);
    $display("Sent %0d bytes over nine register settings and four idling patterns.",
             total_bytes);
    $display("Checked %0d payload beats and %0d ok, %0d header, %0d size, %0d checksum statuses.",
             sb.payload_beats, sb.status_seen[StOk], sb.status_seen[StHeader],
             sb.status_seen[StSize], sb.status_seen[StCsum]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[framed_packet_receiver_unit] OK");
    end else begin
      $display("[framed_packet_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule
